>>> rtl/lcwr_pkg.sv
// Package for the load-cell weight reporter: shared types and constants.
// No dependencies; used by every module in rtl/ except lcwr_checker.
package lcwr_pkg;

    localparam int RAW_W    = 24;
    localparam int DIV_W    = 16;
    localparam int KG_W     = 8;
    localparam int GRAMS_W  = 28;
    localparam int DIGIT_W  = 4;
    localparam int HIGH_W   = 8;
    localparam int LOW_W    = 7;
    localparam int CFG_IDX_W = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_OFFSET     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_UNIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_KILOGRAMS   = 2'd2;

    localparam logic [RAW_W-1:0] TARE_RESET = 24'd0;
    localparam logic [DIV_W-1:0] CPU_RESET  = 16'd228;
    localparam logic [KG_W-1:0]  MAXKG_RESET = 8'd95;

    // x / 10 == (x * RECIP_10) >> RECIP_SHIFT for every 24-bit x
    localparam logic [RAW_W-1:0] RECIP_10    = 24'hCCCCCD;
    localparam int               RECIP_SHIFT = 27;
    localparam int               QUO_W       = 2 * RAW_W - RECIP_SHIFT;

    localparam int NUM_DIGITS = 4;
    localparam logic [RAW_W-1:0] ALARM_QUOTIENT = 24'd10000; // 100000 g / 10
    localparam logic [HIGH_W-1:0] HIGH_BASE     = 8'd100;
    localparam logic [LOW_W-1:0]  NEAR_LIMIT    = 7'd10;
    localparam logic [3:0]        REPEAT_LIMIT  = 4'd10;

    localparam int QUEUE_DEPTH = 2;

    typedef logic [RAW_W-1:0] net_t;

    typedef struct packed {
        logic [DIV_W-1:0] counts_per_unit;
        logic [KG_W-1:0]  max_kilograms;
    } cfg_t;

    typedef struct packed {
        logic [GRAMS_W-1:0] weight_grams;
        logic [DIGIT_W-1:0] tens_kg;
        logic [DIGIT_W-1:0] units_kg;
        logic [DIGIT_W-1:0] tenths_kg;
        logic [DIGIT_W-1:0] hundredths_kg;
        logic [HIGH_W-1:0]  high_report_byte;
        logic [LOW_W-1:0]   low_report_byte;
        logic               report_valid;
        logic               overload_alarm;
    } result_t;

endpackage

>>> rtl/load_cell_weight_reporter.sv
// Path from an accepted s_ beat to the m_ beat: front register, queue, serial
// divider, digit steps, result load.
// The back end works on one item at a time and takes a new item only once the
// last result is loaded (a load, 24 divider iterations, 4 digit steps, a finish).
// Reset: synchronous active-low aresetn clears handshakes, queue and filter
// state and restores the register defaults (tare 0, 228 counts, 95 kg).
module load_cell_weight_reporter (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] raw_count
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [27:0] weight_grams, [31:28] tens_kg, [35:32] units_kg,
    // [39:36] tenths_kg, [43:40] hundredths_kg, [51:44] high_report_byte,
    // [58:52] low_report_byte, [63:59] zero
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser,   // [0] report_valid, [1] overload_alarm
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [lcwr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0] cfg_data
);

    // configuration registers
    logic [lcwr_pkg::RAW_W-1:0] tare_reg;
    logic [lcwr_pkg::DIV_W-1:0] cpu_reg;
    logic [lcwr_pkg::KG_W-1:0]  maxkg_reg;
    lcwr_pkg::cfg_t             cfg;

    assign cfg_ready = 1'b1;   // writes always taken in one beat
    assign cfg.counts_per_unit = cpu_reg;
    assign cfg.max_kilograms   = maxkg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tare_reg  <= lcwr_pkg::TARE_RESET;
            cpu_reg   <= lcwr_pkg::CPU_RESET;
            maxkg_reg <= lcwr_pkg::MAXKG_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                lcwr_pkg::CFG_TARE_OFFSET:     tare_reg  <= cfg_data;
                lcwr_pkg::CFG_COUNTS_PER_UNIT: cpu_reg   <= cfg_data[lcwr_pkg::DIV_W-1:0];
                lcwr_pkg::CFG_MAX_KILOGRAMS:   maxkg_reg <= cfg_data[lcwr_pkg::KG_W-1:0];
                default: ;  // unmapped index: beat accepted, ignored
            endcase
        end
    end

    // front end -> queue -> back end
    logic              f_valid;
    logic              f_ready;
    lcwr_pkg::net_t    f_net;
    logic              q_valid;
    logic              q_ready;
    lcwr_pkg::net_t    q_net;
    lcwr_pkg::result_t res;

    lcwr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .raw_count   (s_tdata),
        .tare_offset (tare_reg),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .out_net     (f_net)
    );

    lcwr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_net),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_net)
    );

    lcwr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_net     (q_net),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    // pack the result beat, first field lowest
    assign m_tdata = {5'd0,
                      res.low_report_byte,
                      res.high_report_byte,
                      res.hundredths_kg,
                      res.tenths_kg,
                      res.units_kg,
                      res.tens_kg,
                      res.weight_grams};
    assign m_tuser = {res.overload_alarm, res.report_valid};

endmodule

>>> rtl/lcwr_front.sv
// Front end: takes raw counts, removes the tare and registers the net count.
// Depends on lcwr_pkg.
module lcwr_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [lcwr_pkg::RAW_W-1:0] raw_count,
    input  logic [lcwr_pkg::RAW_W-1:0] tare_offset,
    output logic                    out_valid,
    input  logic                    out_ready,
    output lcwr_pkg::net_t          out_net
);

    logic           valid_reg;
    lcwr_pkg::net_t net_reg;
    lcwr_pkg::net_t net_next;

    // negative difference clamps to zero
    assign net_next = (raw_count >= tare_offset) ? (raw_count - tare_offset) : '0;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_net   = net_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            net_reg <= net_next;
        end
    end

endmodule

>>> rtl/lcwr_queue.sv
// Short queue of net counts between front and back ends.
// Depends on lcwr_pkg.
module lcwr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  lcwr_pkg::net_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output lcwr_pkg::net_t out_data
);

    localparam int PTR_W = $clog2(lcwr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(lcwr_pkg::QUEUE_DEPTH + 1);

    lcwr_pkg::net_t   mem [lcwr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(lcwr_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(lcwr_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= ptr_inc(wptr_reg);
            end
            if (pop) begin
                rptr_reg <= ptr_inc(rptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= in_data;
        end
    end

endmodule

>>> rtl/lcwr_back.sv
// Back end: serial divider, decimal digit extraction, stability filter and
// output register. Depends on lcwr_pkg.
module lcwr_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  lcwr_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  lcwr_pkg::net_t   in_net,
    output logic             out_valid,
    input  logic             out_ready,
    output lcwr_pkg::result_t out_result
);

    localparam int RAW_W   = lcwr_pkg::RAW_W;
    localparam int DIV_W   = lcwr_pkg::DIV_W;
    localparam int QUO_W   = lcwr_pkg::QUO_W;
    localparam int CNT_W   = $clog2(RAW_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DIG  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]           state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [RAW_W-1:0]     dvd_reg;     // dividend, becomes quotient
    logic [DIV_W-1:0]     rem_reg;
    logic [RAW_W-1:0]     x_reg;
    logic [lcwr_pkg::DIGIT_W-1:0] dig_reg [lcwr_pkg::NUM_DIGITS];
    logic                 alarm_kg_reg;
    logic [lcwr_pkg::HIGH_W-1:0] ref_hi_reg;
    logic [lcwr_pkg::LOW_W-1:0]  ref_lo_reg;
    logic [3:0]           rpt_reg;
    logic                 out_valid_reg;
    lcwr_pkg::result_t    out_reg;

    // divider step
    logic [DIV_W-1:0]     divisor;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       trial_sub;
    logic                 trial_ge;

    assign divisor   = (cfg.counts_per_unit == '0) ? DIV_W'(1) : cfg.counts_per_unit;
    assign trial     = {rem_reg, dvd_reg[RAW_W-1]};
    assign trial_ge  = (trial >= {1'b0, divisor});
    assign trial_sub = trial - {1'b0, divisor};

    // digit step: divide by ten through the reciprocal
    logic [RAW_W-1:0]     x_src;
    logic [2*RAW_W-1:0]   prod;
    logic [QUO_W-1:0]     quo;
    logic [RAW_W-1:0]     quo_ten;
    logic [RAW_W-1:0]     rem10;

    assign x_src   = (cnt_reg == '0) ? dvd_reg : x_reg;
    assign prod    = x_src * lcwr_pkg::RECIP_10;
    assign quo     = prod[2*RAW_W-1:lcwr_pkg::RECIP_SHIFT];
    assign quo_ten = (RAW_W'(quo) << 3) + (RAW_W'(quo) << 1);
    assign rem10   = x_src - quo_ten;

    // result assembly
    logic [lcwr_pkg::HIGH_W-1:0] hi;
    logic [lcwr_pkg::LOW_W-1:0]  lo;
    logic [lcwr_pkg::LOW_W-1:0]  diff;
    logic                        near;
    logic                        load;
    logic [lcwr_pkg::GRAMS_W-1:0] grams;
    lcwr_pkg::result_t           res;

    // digit order: 0 hundredths, 1 tenths, 2 units, 3 tens
    assign hi = lcwr_pkg::HIGH_BASE
              + ({4'd0, dig_reg[3]} << 3) + ({4'd0, dig_reg[3]} << 1)
              + {4'd0, dig_reg[2]};
    assign lo = ({3'd0, dig_reg[1]} << 3) + ({3'd0, dig_reg[1]} << 1)
              + {3'd0, dig_reg[0]};
    assign diff  = (lo > ref_lo_reg) ? (lo - ref_lo_reg) : (ref_lo_reg - lo);
    assign near  = (hi == ref_hi_reg) && (diff < lcwr_pkg::NEAR_LIMIT);
    assign grams = ({4'd0, dvd_reg} << 3) + ({4'd0, dvd_reg} << 1);
    assign load  = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    always_comb begin
        res.weight_grams     = grams;
        res.tens_kg          = dig_reg[3];
        res.units_kg         = dig_reg[2];
        res.tenths_kg        = dig_reg[1];
        res.hundredths_kg    = dig_reg[0];
        res.high_report_byte = hi;
        res.low_report_byte  = lo;
        res.report_valid     = !near || (rpt_reg < lcwr_pkg::REPEAT_LIMIT);
        res.overload_alarm   = alarm_kg_reg || (dvd_reg >= lcwr_pkg::ALARM_QUOTIENT);
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ref_hi_reg    <= '0;
            ref_lo_reg    <= '0;
            rpt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == CNT_W'(RAW_W - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DIG;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DIG: begin
                    if (cnt_reg == CNT_W'(lcwr_pkg::NUM_DIGITS - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_FIN;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_FIN: begin
                    if (load) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        if (near) begin
                            if (rpt_reg < lcwr_pkg::REPEAT_LIMIT) begin
                                rpt_reg <= rpt_reg + 1'b1;
                            end
                        end else begin
                            rpt_reg    <= '0;
                            ref_hi_reg <= hi;
                            ref_lo_reg <= lo;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && in_valid) begin
            dvd_reg <= in_net;
            rem_reg <= '0;
        end
        if (state_reg == ST_DIV) begin
            rem_reg <= trial_ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
            dvd_reg <= {dvd_reg[RAW_W-2:0], trial_ge};
        end
        if (state_reg == ST_DIG) begin
            dig_reg[cnt_reg[1:0]] <= rem10[lcwr_pkg::DIGIT_W-1:0];
            x_reg                 <= RAW_W'(quo);
            if (cnt_reg == CNT_W'(1)) begin
                // quo is now net quotient / 100 = whole kilograms
                alarm_kg_reg <= (quo >= QUO_W'(cfg.max_kilograms));
            end
        end
        if (load) begin
            out_reg <= res;
        end
    end

endmodule

>>> rtl/lcwr_checker.sv
// Port-level checks on the result stream of the weight reporter, with bind.
// Depends on load_cell_weight_reporter.
module lcwr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    logic [6:0] low_expect;
    assign low_expect = ({3'd0, m_tdata[39:36]} << 3) + ({3'd0, m_tdata[39:36]} << 1)
                      + {3'd0, m_tdata[43:40]};

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_high_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[51:44] >= 8'd100) && (m_tdata[51:44] <= 8'd199))
        else $error("high report byte out of range");

    a_low_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[58:52] == low_expect)
        else $error("low report byte disagrees with its digits");

    a_overload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[27:0] >= 28'd100000) |-> m_tuser[1])
        else $error("overload not flagged at 100000 g");

endmodule

bind load_cell_weight_reporter lcwr_checker u_lcwr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
